@@ design/fsab_pkg.sv @@
// Shared types and constants for the FIFO slot arbiter.
package fsab_pkg;

   localparam int unsigned PORT_COUNT    = 16;
   localparam int unsigned QUEUE_DEPTH   = 16;
   localparam int unsigned LINK_PORTS    = 16;
   localparam logic [4:0]  ACTIVE_RESET  = 5'd16;

   typedef enum logic [1:0] {
      FUNC_REQUEST    = 2'd0,
      FUNC_DATA       = 2'd1,
      FUNC_DONE       = 2'd2,
      FUNC_DISCONNECT = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ACT_IGNORED   = 3'd0,
      ACT_GRANTED   = 3'd1,
      ACT_QUEUED    = 3'd2,
      ACT_FORWARDED = 3'd3,
      ACT_RELEASED  = 3'd4,
      ACT_DROPPED   = 3'd5
   } action_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [3:0] port;
   } queue_cmd_type;

   typedef struct packed {
      logic [3:0] head_port;
      logic [4:0] fill;
   } queue_stat_type;

endpackage

@@ design/fsab_if.sv @@
// Channel interfaces: event input, result output and register write.
interface fsab_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [3:0] source;

   modport source_mp (output valid, func, source, input ready);
   modport sink_mp   (input valid, func, source, output ready);
endinterface

interface fsab_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic        grant_valid;
   logic [3:0]  grant_target;
   logic [15:0] forward_mask;
   logic        holder_valid;
   logic [3:0]  holder_port;
   logic [4:0]  waiting_count;

   modport source_mp (output valid, action, grant_valid, grant_target, forward_mask,
                      holder_valid, holder_port, waiting_count, input ready);
   modport sink_mp   (input valid, action, grant_valid, grant_target, forward_mask,
                      holder_valid, holder_port, waiting_count, output ready);
endinterface

interface fsab_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] data;

   modport source_mp (output valid, data, input ready);
   modport sink_mp   (input valid, data, output ready);
endinterface

@@ design/fsab_queue.sv @@
// Waiting-port FIFO: circular buffer of port numbers with fill count.
module fsab_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  fsab_pkg::queue_cmd_type cmd,
   output fsab_pkg::queue_stat_type stat
);
   import fsab_pkg::*;

   logic [3:0] wait_fifo_ff [QUEUE_DEPTH];
   logic [3:0] head_port_ff;
   logic [3:0] head_ff, head_in;
   logic [3:0] tail_ff, tail_in;
   logic [4:0] fill_ff, fill_in;

   always_comb begin
      head_in = cmd.pop  ? head_ff + 4'd1 : head_ff;
      tail_in = cmd.push ? tail_ff + 4'd1 : tail_ff;
      fill_in = fill_ff + {4'd0, cmd.push} - {4'd0, cmd.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   // head entry kept in a register; refilled from the next slot on a pop
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         wait_fifo_ff[tail_ff] <= cmd.port;
      end
      if (cmd.push && fill_ff == 5'd0) begin
         head_port_ff <= cmd.port;
      end else if (cmd.pop) begin
         head_port_ff <= wait_fifo_ff[head_in];
      end
   end

   assign stat.head_port = head_port_ff;
   assign stat.fill      = fill_ff;

endmodule

@@ design/fifo_slot_arbiter_broadcast.sv @@
// Top level: shared transmit slot arbiter with waiting queue and data fan-out.
// The result of a transferred event is registered and shows on the output in the next cycle.
// Throughput: one event per cycle; input stalls only while the result is held.
// Register writes are always accepted and take effect on the next event.
// Synchronous reset: slot free, queue empty, all links up, active count 16.
module fifo_slot_arbiter_broadcast (
   input logic        clock,
   input logic        reset,
   fsab_req_if.sink_mp   req_chan,
   fsab_rsp_if.source_mp rsp_chan,
   fsab_csr_if.sink_mp   csr_chan
);
   import fsab_pkg::*;

   logic [4:0]  active_count_ff;
   logic        slot_busy_ff, slot_busy_in;
   logic [3:0]  slot_owner_ff, slot_owner_in;
   logic [15:0] link_up_ff, link_up_in;

   logic        rsp_valid_ff;
   action_type  action_ff, action_in;
   logic        grant_valid_ff, grant_valid_in;
   logic [3:0]  grant_target_ff, grant_target_in;
   logic [15:0] forward_mask_ff, forward_mask_in;
   logic        holder_valid_ff;
   logic [3:0]  holder_port_ff;
   logic [4:0]  waiting_count_ff, waiting_count_in;

   queue_cmd_type  q_cmd;
   queue_stat_type q_stat;

   logic       req_fire;
   logic       usable;
   logic       is_holder;
   logic [3:0] src;
   func_type   func;

   fsab_queue u_queue (
      .clock (clock),
      .reset (reset),
      .cmd   (q_cmd),
      .stat  (q_stat)
   );

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign src       = req_chan.source;
   assign func      = func_type'(req_chan.func);
   assign usable    = (32'(src) < PORT_COUNT) && link_up_ff[src];
   assign is_holder = slot_busy_ff && (slot_owner_ff == src);

   always_comb begin
      slot_busy_in    = slot_busy_ff;
      slot_owner_in   = slot_owner_ff;
      link_up_in      = link_up_ff;
      action_in       = ACT_IGNORED;
      grant_valid_in  = 1'b0;
      grant_target_in = '0;
      forward_mask_in = '0;
      q_cmd.push      = 1'b0;
      q_cmd.pop       = 1'b0;
      q_cmd.port      = src;

      if (req_fire && usable) begin
         case (func)
            FUNC_REQUEST: begin
               if (!slot_busy_ff) begin
                  slot_busy_in    = 1'b1;
                  slot_owner_in   = src;
                  grant_valid_in  = 1'b1;
                  grant_target_in = src;
                  action_in       = ACT_GRANTED;
               end else if (32'(q_stat.fill) < QUEUE_DEPTH) begin
                  q_cmd.push = 1'b1;
                  action_in  = ACT_QUEUED;
               end else begin
                  action_in = ACT_DROPPED;
               end
            end
            FUNC_DATA: begin
               if (is_holder) begin
                  for (int j = 0; j < LINK_PORTS; j++) begin
                     forward_mask_in[j] = (5'(j) < active_count_ff) && (j < PORT_COUNT)
                                          && (4'(j) != src) && link_up_ff[j];
                  end
                  action_in = ACT_FORWARDED;
               end
            end
            FUNC_DONE, FUNC_DISCONNECT: begin
               if (func == FUNC_DISCONNECT) begin
                  link_up_in[src] = 1'b0;
               end
               if (is_holder) begin
                  slot_busy_in  = 1'b0;
                  slot_owner_in = '0;
                  action_in     = ACT_RELEASED;
                  if (q_stat.fill != 5'd0) begin
                     q_cmd.pop       = 1'b1;
                     slot_busy_in    = 1'b1;
                     slot_owner_in   = q_stat.head_port;
                     grant_valid_in  = 1'b1;
                     grant_target_in = q_stat.head_port;
                  end
               end
            end
            default: begin
               action_in = ACT_IGNORED;
            end
         endcase
      end

      waiting_count_in = q_stat.fill + {4'd0, q_cmd.push} - {4'd0, q_cmd.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_count_ff <= ACTIVE_RESET;
         slot_busy_ff    <= 1'b0;
         slot_owner_ff   <= '0;
         link_up_ff      <= '1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            active_count_ff <= csr_chan.data;
         end
         slot_busy_ff  <= slot_busy_in;
         slot_owner_ff <= slot_owner_in;
         link_up_ff    <= link_up_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff        <= action_in;
         grant_valid_ff   <= grant_valid_in;
         grant_target_ff  <= grant_target_in;
         forward_mask_ff  <= forward_mask_in;
         holder_valid_ff  <= slot_busy_in;
         holder_port_ff   <= slot_owner_in;
         waiting_count_ff <= waiting_count_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.action        = action_ff;
   assign rsp_chan.grant_valid   = grant_valid_ff;
   assign rsp_chan.grant_target  = grant_target_ff;
   assign rsp_chan.forward_mask  = forward_mask_ff;
   assign rsp_chan.holder_valid  = holder_valid_ff;
   assign rsp_chan.holder_port   = holder_port_ff;
   assign rsp_chan.waiting_count = waiting_count_ff;

   // a free slot always means nobody is waiting
   a_free_slot_empty_queue: assert property (@(posedge clock) disable iff (reset)
      !slot_busy_ff |-> q_stat.fill == 5'd0)
      else $error("slot free with ports waiting");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted event produced no result");

   a_grant_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && grant_valid_ff |-> action_ff == ACT_GRANTED
                                         || action_ff == ACT_RELEASED)
      else $error("grant on non-grant action");

   a_no_self_forward: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && action_ff == ACT_FORWARDED |-> !forward_mask_ff[holder_port_ff])
      else $error("data forwarded back to holder");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.fill <= 5'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");

endmodule
